### hdl/pibr_pkg.sv
// shared constants, types and helpers of the pulse-interval bus receiver
package pibr_pkg;

   // fixed field widths
   localparam int FUNC_W       = 2;
   localparam int TIME_W       = 16;
   localparam int BASE_W       = 12;
   localparam int BYTE_W       = 8;
   localparam int SYM_W        = 2;
   localparam int INDEX_W      = 8;
   localparam int THR_W        = 15;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 2;

   // defaults of the top-level parameters
   localparam int FIFO_DEPTH_DEFAULT = 64;
   localparam int INDEX_BITS_DEFAULT = 4;
   localparam int COUNT_W_DEFAULT    = $clog2(FIFO_DEPTH_DEFAULT + 1);

   // frame layout and symbol codes
   localparam logic [SYM_W-1:0]   END_SYMBOL        = 2'd2;
   localparam int                 LAST_DATA_BIT     = 7;
   localparam logic [INDEX_W-1:0] PRIOR_INDEX_RESET = 8'hFF;
   localparam logic [BASE_W-1:0]  SYMBOL_BASE_RESET = 12'd20;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_EDGE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd2;

   // command kinds handed from front to back
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_SYMBOL = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   // register addresses
   localparam logic [CSR_ADDR_W-1:0] REG_SYMBOL_BASE = 2'd0;

   // symbol base plus the thresholds derived from it
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              base_zero;
      logic [THR_W-1:0]  thr_one;    // 3*base + 1
      logic [THR_W-1:0]  thr_end;    // 5*base + 1
      logic [TIME_W-1:0] dline_off;  // 2*(3*base + base/2)
   } cfg_type;

   // classified request
   typedef struct packed {
      logic [1:0]        kind;
      logic [SYM_W-1:0]  sym;
      logic              dset;
      logic [TIME_W-1:0] deadline;
   } cmd_type;

   function automatic cfg_type make_cfg(input logic [BASE_W-1:0] b);
      logic [TIME_W-1:0] b16;
      cfg_type           c;
      b16         = {4'b0, b};
      c.base      = b;
      c.base_zero = (b == '0);
      c.thr_one   = THR_W'((b16 << 1) + b16 + 16'd1);
      c.thr_end   = THR_W'((b16 << 2) + b16 + 16'd1);
      c.dline_off = (b16 << 2) + (b16 << 1) + {b16[TIME_W-1:1], 1'b0};
      return c;
   endfunction

endpackage

### hdl/pibr_chan_if.sv
// request and response channel interfaces
interface pibr_req_if import pibr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [TIME_W-1:0] edge_time;

   modport source (output valid, func, edge_time, input ready);
   modport sink   (input valid, func, edge_time, output ready);
endinterface

interface pibr_rsp_if import pibr_pkg::*; #(parameter int COUNT_W = COUNT_W_DEFAULT) ();
   logic               valid;
   logic               ready;
   logic               byte_valid;
   logic [BYTE_W-1:0]  byte_data;
   logic [COUNT_W-1:0] bytes_available;
   logic               deadline_set;
   logic [TIME_W-1:0]  deadline;

   modport source (output valid, byte_valid, byte_data, bytes_available, deadline_set,
                   deadline, input ready);
   modport sink   (input valid, byte_valid, byte_data, bytes_available, deadline_set,
                   deadline, output ready);
endinterface

### hdl/pibr_csr.sv
// symbol base register with derived decode thresholds
module pibr_csr import pibr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);
   cfg_type cfg_ff, cfg_in;
   logic    wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == REG_SYMBOL_BASE);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         cfg_in = make_cfg(csr_pwdata[BASE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= make_cfg(SYMBOL_BASE_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_SYMBOL_BASE) ?
                       {{(CSR_DATA_W-BASE_W){1'b0}}, cfg_ff.base} : '0;
   assign cfg = cfg_ff;
endmodule

### hdl/pibr_front.sv
// front end: edge timing, noise filter, symbol decode and deadline
module pibr_front import pibr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   pibr_req_if.sink       req_if,
   input  logic           q_full,
   output logic           push,
   output cmd_type        cmd
);
   logic [TIME_W-1:0] last_ff, last_in;
   logic              seen_ff, seen_in;
   logic [TIME_W-1:0] gap;
   logic [TIME_W-1:0] dline;
   logic [SYM_W-1:0]  sym;

   assign req_if.ready = !q_full;
   assign push = req_if.valid && !q_full;

   assign gap   = req_if.edge_time - last_ff;
   assign dline = req_if.edge_time + cfg.dline_off;

   // thresholds replace the divide: 0 below 3b+1, 1 below 5b+1, else end; a zero base always gives end
   always_comb begin
      if (cfg.base_zero) begin
         sym = END_SYMBOL;
      end else if (gap >= {1'b0, cfg.thr_end}) begin
         sym = END_SYMBOL;
      end else if (gap >= {1'b0, cfg.thr_one}) begin
         sym = 2'd1;
      end else begin
         sym = 2'd0;
      end
   end

   always_comb begin
      last_in = last_ff;
      seen_in = seen_ff;
      cmd     = '0;
      unique case (req_if.func)
         FUNC_EDGE: begin
            if (!seen_ff) begin
               last_in      = req_if.edge_time;
               seen_in      = 1'b1;
               cmd.dset     = 1'b1;
               cmd.deadline = dline;
            end else if (gap >= {4'b0, cfg.base}) begin
               last_in      = req_if.edge_time;
               cmd.kind     = CMD_SYMBOL;
               cmd.sym      = sym;
               cmd.dset     = 1'b1;
               cmd.deadline = dline;
            end
         end
         FUNC_TIMEOUT: begin
            if (seen_ff) begin
               seen_in  = 1'b0;
               cmd.kind = CMD_SYMBOL;
               cmd.sym  = END_SYMBOL;
            end
         end
         FUNC_POP: begin
            cmd.kind = CMD_POP;
         end
         default: begin
            cmd.kind = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         seen_ff <= 1'b0;
      end else if (push) begin
         last_ff <= last_in;
         seen_ff <= seen_in;
      end
   end
endmodule

### hdl/pibr_queue.sv
// short command queue between front and back
module pibr_queue import pibr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hdl/pibr_back.sv
// back end: frame assembly, byte store and response register
module pibr_back import pibr_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   pibr_rsp_if.source rsp_if
);
   localparam int SLOT_W       = $clog2(FIFO_DEPTH);
   localparam int COUNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int PARITY_POS   = LAST_DATA_BIT + INDEX_BITS + 1;
   localparam int COMPLETE_POS = LAST_DATA_BIT + INDEX_BITS + 2;
   localparam int OVERLONG_POS = LAST_DATA_BIT + INDEX_BITS + 3;
   localparam int POS_W        = $clog2(OVERLONG_POS + 1);

   logic [BYTE_W-1:0]  mem [FIFO_DEPTH];

   logic [SLOT_W-1:0]  ws_ff, ws_in;
   logic [SLOT_W-1:0]  rs_ff, rs_in;
   logic [COUNT_W-1:0] held_ff, held_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               par_ff, par_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [INDEX_W-1:0] prior_ff, prior_in;
   logic [BYTE_W-1:0]  asm_ff, asm_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               byte_valid_ff, byte_valid_in;
   logic [BYTE_W-1:0]  byte_data_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               dset_ff;
   logic [TIME_W-1:0]  deadline_ff;

   logic               exec;
   logic               commit;
   logic               pop_hit;
   logic [BYTE_W-1:0]  base_byte;
   logic               base_par;
   logic [INDEX_W-1:0] base_idx;
   logic [POS_W-1:0]   idx_shift;

   assign exec    = cmd_valid && (!rsp_valid_ff || rsp_if.ready);
   assign cmd_pop = exec;

   // a frame restarts its accumulators on its first bit
   assign base_byte = (pos_ff == '0) ? '0 : asm_ff;
   assign base_par  = (pos_ff == '0) ? 1'b0 : par_ff;
   assign base_idx  = (pos_ff == '0) ? '0 : idx_ff;
   assign idx_shift = pos_ff - POS_W'(LAST_DATA_BIT);

   always_comb begin
      ws_in    = ws_ff;
      rs_in    = rs_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      par_in   = par_ff;
      idx_in   = idx_ff;
      prior_in = prior_ff;
      asm_in   = asm_ff;
      commit   = 1'b0;
      pop_hit  = 1'b0;
      if (exec) begin
         unique case (cmd.kind)
            CMD_SYMBOL: begin
               // full store: symbol dropped
               if (held_ff < COUNT_W'(FIFO_DEPTH)) begin
                  if (cmd.sym < END_SYMBOL) begin
                     if (pos_ff <= POS_W'(LAST_DATA_BIT)) begin
                        asm_in = base_byte | (BYTE_W'(cmd.sym[0]) << pos_ff[2:0]);
                        par_in = base_par ^ cmd.sym[0];
                        idx_in = base_idx;
                        pos_in = pos_ff + 1'b1;
                     end else if (pos_ff <= POS_W'(LAST_DATA_BIT + INDEX_BITS)) begin
                        idx_in = idx_ff | (INDEX_W'(cmd.sym[0]) << idx_shift);
                        par_in = par_ff ^ cmd.sym[0];
                        pos_in = pos_ff + 1'b1;
                     end else if (pos_ff == POS_W'(PARITY_POS)) begin
                        par_in = par_ff ^ cmd.sym[0];
                        pos_in = POS_W'(COMPLETE_POS);
                     end else begin
                        pos_in = POS_W'(OVERLONG_POS);
                     end
                  end else begin
                     if (pos_ff == POS_W'(COMPLETE_POS) && !par_ff && idx_ff != prior_ff) begin
                        commit   = 1'b1;
                        held_in  = held_ff + 1'b1;
                        ws_in    = (ws_ff == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : ws_ff + 1'b1;
                        prior_in = idx_ff;
                     end
                     pos_in = '0;
                  end
               end
            end
            CMD_POP: begin
               if (held_ff != '0) begin
                  pop_hit = 1'b1;
                  held_in = held_ff - 1'b1;
                  rs_in   = (rs_ff == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : rs_ff + 1'b1;
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      byte_valid_in = byte_valid_ff;
      if (exec) begin
         rsp_valid_in  = 1'b1;
         byte_valid_in = pop_hit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // byte store, read data lands straight in the response register
   always_ff @(posedge clock) begin
      if (commit) begin
         mem[ws_ff] <= asm_ff;
      end
      if (exec) begin
         byte_data_ff <= pop_hit ? mem[rs_ff] : '0;
         count_ff     <= held_in;
         dset_ff      <= cmd.dset;
         deadline_ff  <= cmd.deadline;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff         <= '0;
         rs_ff         <= '0;
         held_ff       <= '0;
         pos_ff        <= '0;
         par_ff        <= 1'b0;
         idx_ff        <= '0;
         prior_ff      <= PRIOR_INDEX_RESET;
         asm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         byte_valid_ff <= 1'b0;
      end else begin
         ws_ff         <= ws_in;
         rs_ff         <= rs_in;
         held_ff       <= held_in;
         pos_ff        <= pos_in;
         par_ff        <= par_in;
         idx_ff        <= idx_in;
         prior_ff      <= prior_in;
         asm_ff        <= asm_in;
         rsp_valid_ff  <= rsp_valid_in;
         byte_valid_ff <= byte_valid_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.byte_valid      = byte_valid_ff;
   assign rsp_if.byte_data       = byte_data_ff;
   assign rsp_if.bytes_available = count_ff;
   assign rsp_if.deadline_set    = dset_ff;
   assign rsp_if.deadline        = deadline_ff;
endmodule

### hdl/pulse_interval_bus_receiver_core.sv
// top level of the pulse-interval bus receiver
//
//   channel  | direction | handshake            | contents
//   ---------+-----------+----------------------+------------------------------------
//   req_if   | in        | valid / ready        | func, edge_time
//   rsp_if   | out       | valid / ready        | byte_valid, byte_data, bytes_available,
//            |           |                      | deadline_set, deadline
//   csr_*    | in        | psel/penable/pwrite  | symbol_base at byte address 0
//
// one request is taken per cycle while the command queue has room
// a request passes through a queue entry, then the response register, before its response is valid
// the back end applies one command per cycle while its response register is empty or being taken
// a stalled response holds in the output register while the queue keeps filling
// reset is synchronous; no clearing pass, the byte store is only read where written
module pulse_interval_bus_receiver_core import pibr_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   pibr_req_if.sink              req_if,
   pibr_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   // decoded symbol base and thresholds
   cfg_type cfg;

   // front to queue
   logic    push;
   logic    q_full;
   cmd_type push_cmd;

   // queue to back
   logic    q_not_empty;
   logic    q_pop;
   cmd_type head_cmd;

   // configuration register, thresholds worked out once per write
   pibr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // noise filter, gap to symbol classification, deadline
   pibr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push),
      .cmd    (push_cmd)
   );

   // decouples the request side from response stalls
   pibr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // frame assembly, frame checks, byte store and response register
   pibr_back #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_if    (rsp_if)
   );
endmodule

### sim/pibr_scoreboard.sv
`timescale 1ns / 100ps
// scoreboard of the pulse-interval bus receiver: predicts each response and compares it
module pibr_scoreboard import pibr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [TIME_W-1:0]          req_edge_time,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_byte_valid,
   input  logic [BYTE_W-1:0]          rsp_byte_data,
   input  logic [COUNT_W_DEFAULT-1:0] rsp_bytes_available,
   input  logic                       rsp_deadline_set,
   input  logic [TIME_W-1:0]          rsp_deadline,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic                       csr_pready,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output int                         fail_count,
   output int                         pending,
   output int                         bytes_popped
);

   localparam int DEPTH        = FIFO_DEPTH_DEFAULT;
   localparam int SLOT_W       = $clog2(DEPTH);
   localparam int COUNT_W      = COUNT_W_DEFAULT;
   localparam int PARITY_POS   = LAST_DATA_BIT + INDEX_BITS_DEFAULT + 1;
   localparam int COMPLETE_POS = LAST_DATA_BIT + INDEX_BITS_DEFAULT + 2;
   localparam int OVERLONG_POS = LAST_DATA_BIT + INDEX_BITS_DEFAULT + 3;

   typedef struct packed {
      logic               byte_valid;
      logic [BYTE_W-1:0]  byte_data;
      logic [COUNT_W-1:0] bytes_available;
      logic               deadline_set;
      logic [TIME_W-1:0]  deadline;
   } bus_reply_type;

   // receiver state as the block should hold it
   logic [BYTE_W-1:0]  byte_store [DEPTH];
   logic [SLOT_W-1:0]  wr_slot, rd_slot;
   logic [COUNT_W-1:0] held;
   logic [3:0]         bit_pos;
   logic               parity;
   logic [INDEX_W-1:0] frame_idx, prior_idx;
   logic [TIME_W-1:0]  last_edge;
   logic               armed;
   logic [BASE_W-1:0]  base;

   bus_reply_type due_replies [$];

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < 40)
         $display("%0t ns  mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      fail_count++;
   endtask

   task automatic clear_receiver();
      foreach (byte_store[i]) byte_store[i] = '0;
      wr_slot   = '0;
      rd_slot   = '0;
      held      = '0;
      bit_pos   = '0;
      parity    = 1'b0;
      frame_idx = '0;
      prior_idx = PRIOR_INDEX_RESET;
      last_edge = '0;
      armed     = 1'b0;
      base      = SYMBOL_BASE_RESET;
   endtask

   function automatic logic [SYM_W-1:0] gap_symbol(input logic [TIME_W-1:0] gap);
      int unsigned q;
      if (base == '0) return END_SYMBOL;
      if (gap <= base) return '0;
      q = (int'(gap) - int'(base) - 1) / (2 * int'(base));
      return (q > END_SYMBOL) ? END_SYMBOL : SYM_W'(q);
   endfunction

   // one decoded symbol into the frame being assembled; nothing moves while full
   task automatic take_symbol(input logic [SYM_W-1:0] sym);
      if (held >= DEPTH) return;
      if (sym < END_SYMBOL) begin
         if (bit_pos == 0) begin
            byte_store[wr_slot] = '0;
            parity              = 1'b0;
            frame_idx           = '0;
         end
         if (bit_pos <= LAST_DATA_BIT) begin
            byte_store[wr_slot] = byte_store[wr_slot] | (BYTE_W'(sym) << bit_pos);
            parity  ^= sym[0];
            bit_pos++;
         end else if (bit_pos <= LAST_DATA_BIT + INDEX_BITS_DEFAULT) begin
            frame_idx = frame_idx | (INDEX_W'(sym) << (bit_pos - LAST_DATA_BIT));
            parity  ^= sym[0];
            bit_pos++;
         end else if (bit_pos == PARITY_POS) begin
            parity  ^= sym[0];
            bit_pos  = COMPLETE_POS;
         end else begin
            bit_pos  = OVERLONG_POS;
         end
      end else begin
         if (bit_pos == COMPLETE_POS && !parity && frame_idx != prior_idx) begin
            held++;
            wr_slot   = (wr_slot == DEPTH - 1) ? '0 : wr_slot + 1'b1;
            prior_idx = frame_idx;
         end
         bit_pos = '0;
      end
   endtask

   task automatic predict_reply(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] date,
                                output bus_reply_type r);
      logic [TIME_W-1:0] gap;
      logic              first, take;
      r = '0;
      case (func)
         FUNC_EDGE: begin
            first = !armed;
            gap   = date - last_edge;
            take  = first || gap >= base;
            if (take) begin
               last_edge      = date;
               armed          = 1'b1;
               r.deadline_set = 1'b1;
               r.deadline     = TIME_W'(int'(date) + 2 * (int'(base) * (int'(END_SYMBOL) + 1)
                                        + int'(base) / 2));
               if (!first) take_symbol(gap_symbol(gap));
            end
         end
         FUNC_TIMEOUT: begin
            if (armed) begin
               armed = 1'b0;
               take_symbol(END_SYMBOL);
            end
         end
         FUNC_POP: begin
            if (held != 0) begin
               r.byte_valid = 1'b1;
               r.byte_data  = byte_store[rd_slot];
               held--;
               rd_slot      = (rd_slot == DEPTH - 1) ? '0 : rd_slot + 1'b1;
            end
         end
         default: ;
      endcase
      r.bytes_available = held;
   endtask

   always @(posedge clock) begin
      bus_reply_type want, seen;
      if (reset) begin
         clear_receiver();
         due_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_byte_valid, rsp_byte_data, rsp_bytes_available,
                     rsp_deadline_set, rsp_deadline};
            if (seen.byte_valid === 1'b1) bytes_popped++;
            if (due_replies.size() == 0) begin
               report_mismatch("response with none awaited", 32'd0, 32'd1);
            end else begin
               want = due_replies.pop_front();
               if (seen.byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", 32'(want.byte_valid), 32'(seen.byte_valid));
               if (seen.byte_data !== want.byte_data)
                  report_mismatch("byte_data", 32'(want.byte_data), 32'(seen.byte_data));
               if (seen.bytes_available !== want.bytes_available)
                  report_mismatch("bytes_available", 32'(want.bytes_available),
                                  32'(seen.bytes_available));
               if (seen.deadline_set !== want.deadline_set)
                  report_mismatch("deadline_set", 32'(want.deadline_set),
                                  32'(seen.deadline_set));
               if (seen.deadline !== want.deadline)
                  report_mismatch("deadline", 32'(want.deadline), 32'(seen.deadline));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == REG_SYMBOL_BASE)
            base = csr_pwdata[BASE_W-1:0];
         if (req_valid && req_ready) begin
            predict_reply(req_func, req_edge_time, want);
            due_replies.push_back(want);
         end
      end
      pending = due_replies.size();
   end

endmodule

### sim/tb_pulse_interval_bus_receiver_core.sv
`timescale 1ns / 100ps
// testbench top of the pulse-interval bus receiver core: clock, reset, stimulus and verdict
module tb_pulse_interval_bus_receiver_core;
   import pibr_pkg::*;

   // the one func code the block leaves unused
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int FRAME_BITS  = LAST_DATA_BIT + 1 + INDEX_BITS_DEFAULT + 1;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 16;   // margin after every response has come home
   localparam int LONG_HOLD   = 300;

   // what the stimulus knows about the receiver between frames
   typedef enum int {LINE_UNKNOWN, LINE_IDLE, LINE_ARMED} line_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count, pending, bytes_popped;
   int requests_sent    = 0;
   int settings_used    = 1;
   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;
   bit hold_request     = 1'b0;

   // stimulus view of the bus timeline
   logic [BASE_W-1:0] cur_base   = SYMBOL_BASE_RESET;
   logic [TIME_W-1:0] line_time  = '0;
   logic [3:0]        next_index = '0;
   line_state_type    line_state = LINE_UNKNOWN;

   pibr_req_if req_if();
   pibr_rsp_if rsp_if();

   pulse_interval_bus_receiver_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pibr_scoreboard u_scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_if.valid),
      .req_ready           (req_if.ready),
      .req_func            (req_if.func),
      .req_edge_time       (req_if.edge_time),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_byte_valid      (rsp_if.byte_valid),
      .rsp_byte_data       (rsp_if.byte_data),
      .rsp_bytes_available (rsp_if.bytes_available),
      .rsp_deadline_set    (rsp_if.deadline_set),
      .rsp_deadline        (rsp_if.deadline),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_pready          (csr_pready),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .fail_count          (fail_count),
      .pending             (pending),
      .bytes_popped        (bytes_popped)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d responses outstanding",
                     cycles, pending);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // response side: random stalls per phase, plus one long hold-off on request
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left    = 0;
      hold_taken   = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            // the request queue behind the output register fills and req ready drops
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // one register write: setup cycle, then access cycle
   task automatic write_symbol_base(input logic [BASE_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_SYMBOL_BASE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_base = value;
      settings_used++;
   endtask

   // offer one request, with random idle cycles ahead of it; valid stays up afterwards
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_if.valid     <= 1'b0;
         req_if.func      <= FUNC_W'($urandom);
         req_if.edge_time <= TIME_W'($urandom);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.func      <= func;
      req_if.edge_time <= stamp;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
   endtask

   // drop valid and let every response come home before anything changes
   task automatic settle_receiver();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // gap that decodes to a data bit under the current base, or to the end symbol at a zero base
   function automatic int data_gap(input bit value);
      int b;
      b = int'(cur_base);
      if (b == 0) return $urandom_range(300);
      if (!value) return ($urandom_range(3) == 0) ? b : $urandom_range(3 * b, b);
      return $urandom_range(5 * b, 3 * b + 1);
   endfunction

   // gap that decodes to the end symbol, now and then the longest the timer allows
   function automatic int end_gap();
      int b, hi;
      b  = int'(cur_base);
      hi = 9 * b + 1;
      if (hi > 65535 || $urandom_range(7) == 0) hi = 65535;
      return $urandom_range(hi, 5 * b + 1);
   endfunction

   task automatic send_edge_after(input int gap);
      line_time = line_time + TIME_W'(gap);
      send_request(FUNC_EDGE, line_time);
   endtask

   // an edge too close to the last accepted one; the timeline does not move
   task automatic send_noise_edge();
      if (cur_base != 0)
         send_request(FUNC_EDGE, line_time + TIME_W'($urandom_range(int'(cur_base) - 1)));
   endtask

   // one frame on the wire: data lsb first, index, parity, then the end mark
   task automatic send_frame(input logic [7:0] data, input logic [3:0] idx, input int n_bits,
                             input bit good_parity, input bit by_timeout, input bit noisy);
      logic [19:0] frame_bits;
      frame_bits = {7'($urandom), (^data ^ ^idx ^ !good_parity), idx, data};
      if (line_state == LINE_UNKNOWN)
         send_request(FUNC_TIMEOUT, TIME_W'($urandom));
      if (line_state != LINE_ARMED) begin
         line_time = TIME_W'($urandom);
         send_request(FUNC_EDGE, line_time);
      end
      for (int k = 0; k < n_bits; k++) begin
         if (noisy && $urandom_range(9) == 0) send_noise_edge();
         send_edge_after(data_gap(frame_bits[k]));
      end
      if (by_timeout) begin
         send_request(FUNC_TIMEOUT, TIME_W'($urandom));
         line_state = LINE_IDLE;
      end else begin
         send_edge_after(end_gap());
         line_state = LINE_ARMED;
      end
   endtask

   // well-formed frame with a fresh index, now and then a repeated one
   task automatic send_good_frame(input bit noisy);
      if ($urandom_range(9) != 0) next_index++;
      send_frame(8'($urandom), next_index, FRAME_BITS, 1'b1, 1'($urandom_range(1)), noisy);
   endtask

   task automatic send_pops(input int count);
      repeat (count) send_request(FUNC_POP, TIME_W'($urandom));
   endtask

   // mostly good frames, the rest broken frames, pops, stray requests and timeouts
   task automatic run_mixed(input int budget);
      int start, pick;
      start = requests_sent;
      while (requests_sent - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_good_frame(1'($urandom_range(1)));
         end else if (pick < 72) begin
            // short, overlong or bad parity
            send_frame(8'($urandom), 4'($urandom), $urandom_range(FRAME_BITS + 4),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
         end else if (pick < 87) begin
            send_pops($urandom_range(4, 1));
         end else if (pick < 95) begin
            send_request(FUNC_W'($urandom), TIME_W'($urandom));
            line_state = LINE_UNKNOWN;
         end else begin
            send_request(FUNC_TIMEOUT, TIME_W'($urandom));
            line_state = LINE_UNKNOWN;
         end
      end
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.func      = FUNC_EDGE;
      req_if.edge_time = '0;

      // synchronous reset, released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset value of the symbol base
      set_idling(0, 0);
      send_request(FUNC_TIMEOUT, 16'hFFFF);        // timeout before any edge
      send_request(FUNC_POP, 16'h0000);            // pop with nothing held
      send_request(FUNC_UNUSED, 16'h5A5A);         // spare func code
      line_time = 16'hFFF0;                        // arm just short of the timer wrap
      send_request(FUNC_EDGE, line_time);
      line_state = LINE_ARMED;
      send_request(FUNC_EDGE, line_time + TIME_W'(cur_base) - 1'b1);   // noise edge
      send_frame(8'hFF, 4'hF, FRAME_BITS, 1'b1, 1'b0, 1'b0);
      send_pops(1);
      send_edge_after(int'(cur_base));             // gap exactly one base
      send_request(FUNC_TIMEOUT, 16'h0000);
      line_time = 16'h0000;
      send_request(FUNC_EDGE, line_time);
      send_edge_after(65535);                      // widest gap, lands on 0xffff
      send_request(FUNC_TIMEOUT, 16'hFFFF);
      line_state = LINE_IDLE;
      settle_receiver();

      // narrowest nonzero base, no idling
      write_symbol_base(12'd1);
      run_mixed(30);
      settle_receiver();

      // widest base, sender gaps
      write_symbol_base(12'd4095);
      set_idling(55, 0);
      run_mixed(30);
      settle_receiver();

      // zero base: every gap is an end symbol; long response hold-off here
      write_symbol_base(12'd0);
      set_idling(0, 55);
      hold_request = 1'b1;
      run_mixed(20);
      settle_receiver();

      // offer more good frames than the byte fifo holds, then drain it and keep popping once empty
      write_symbol_base(BASE_W'($urandom_range(40, 2)));
      set_idling(9, 9);
      repeat (FIFO_DEPTH_DEFAULT + 2) send_good_frame(1'b0);
      send_pops(FIFO_DEPTH_DEFAULT + 4);
      settle_receiver();

      // moderate base, mixed traffic again under receiver stalls
      write_symbol_base(BASE_W'($urandom_range(200, 1)));
      set_idling(0, 55);
      run_mixed(40);
      settle_receiver();

      $display("run covered %0d requests across %0d symbol-base settings and four idling mixes",
               requests_sent, settings_used);
      $display("%0d bytes came back through pops, including a fifo filled past capacity",
               bytes_popped);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hdl/pibr_pkg.sv
hdl/pibr_chan_if.sv
hdl/pibr_csr.sv
hdl/pibr_front.sv
hdl/pibr_queue.sv
hdl/pibr_back.sv
hdl/pulse_interval_bus_receiver_core.sv
sim/pibr_scoreboard.sv
sim/tb_pulse_interval_bus_receiver_core.sv
